// ===== rtl/ensc_pkg.sv =====
// ----------------------------------------------------------------------------
// ensc_pkg
// Shared types, constants and arithmetic helpers for the environmental
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ensc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAL_TEMP    = 3'd0,
    CFG_CAL_PRESS_A = 3'd1,
    CFG_CAL_PRESS_B = 3'd2,
    CFG_CAL_PRESS_C = 3'd3,
    CFG_CAL_HUM_A   = 3'd4,
    CFG_CAL_HUM_B   = 3'd5,
    CFG_TEMP_OFFSET = 3'd6
  } cfg_idx_t;

  // compensation constants
  localparam logic [63:0] C_P_TREF   = 64'd128000;
  localparam logic [31:0] C_H_TREF   = 32'd76800;
  localparam logic [63:0] C_P_FULL   = 64'd1048576;
  localparam logic [63:0] C_P_SCALE  = 64'd3125;
  localparam logic [31:0] C_H_MAX    = 32'd419430400;
  localparam logic [31:0] C_H_RND_A  = 32'd16384;
  localparam logic [31:0] C_H_E_OFS  = 32'd2097152;
  localparam logic [31:0] C_H_RND_F  = 32'd8192;
  localparam logic [31:0] C_H_C_OFS  = 32'd32768;
  localparam logic [31:0] C_T_RND    = 32'd128;
  localparam logic [63:0] C_P_BIAS   = 64'h0000_8000_0000_0000;
  localparam int unsigned DIV_BITS   = 64;
  localparam int unsigned FRONT_DEPTH = 12;
  localparam int unsigned BACK_DEPTH  = 5;

  // unpacked calibration coefficients
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
    logic [14:0] offset;
  } cal_t;

  // values that ride along with the divider
  typedef struct packed {
    logic [15:0] tcs;
    logic [15:0] tas;
    logic        neg;
    logic        pvalid;
    logic [31:0] hva;
    logic [31:0] hs;
  } side_t;

  // one divider cell's working set
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
    logic [63:0] dvs;
    side_t       side;
  } div_t;

  // one finished result
  typedef struct packed {
    logic [15:0] temp_centi;
    logic [15:0] temp_adjusted_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;
    logic [16:0] humidity_q22_10;
  } item_t;

  // three 32x32 partial products of a 64-bit wrapping product
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
    return $signed(x) >>> sh;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
    return $signed(x) >>> sh;
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [31:0] sx32_16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx32_12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx32_8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [63:0] sx64_16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic pp_t pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    r.lh = a[31:0] * b[63:32];
    r.hl = a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    logic [31:0] hi;
    hi = p.lh + p.hl;
    return p.ll + {hi, 32'd0};
  endfunction

  // saturate a 33-bit signed value to 16 bits
  function automatic logic [15:0] sat16(input logic [32:0] v);
    logic [15:0] r;
    if ($signed(v) > 33'sd32767) begin
      r = 16'h7fff;
    end else if ($signed(v) < -33'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ensc_front.sv =====
// ----------------------------------------------------------------------------
// ensc_front
// Temperature, pressure setup and humidity front pipeline; prepares the
// operand magnitudes for the pressure divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ensc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire ensc_pkg::cal_t      cal,
  input  wire logic                in_v,
  input  wire logic [19:0]         adc_temp,
  input  wire logic [19:0]         adc_press,
  input  wire logic [15:0]         adc_hum,
  output logic                     out_v,
  output ensc_pkg::div_t           out_d
);

  logic [ensc_pkg::FRONT_DEPTH-1:0] v_r;

  logic [31:0] s1_pv1_r, s1_dd_r;
  logic [19:0] s1_ap_r, s2_ap_r, s3_ap_r, s4_ap_r, s5_ap_r, s6_ap_r;
  logic [19:0] s7_ap_r, s8_ap_r, s9_ap_r;
  logic [15:0] s1_ah_r, s2_ah_r, s3_ah_r, s4_ah_r, s5_ah_r;
  logic [31:0] s2_v1_r, s2_m2_r;
  logic [31:0] s3_tf_r;
  logic [15:0] s4_tcs_r, s5_tcs_r, s6_tcs_r, s7_tcs_r, s8_tcs_r, s9_tcs_r;
  logic [15:0] s10_tcs_r, s11_tcs_r;
  logic [15:0] s4_tas_r, s5_tas_r, s6_tas_r, s7_tas_r, s8_tas_r, s9_tas_r;
  logic [15:0] s10_tas_r, s11_tas_r;
  logic [63:0] s4_w1_r;
  logic [31:0] s4_hv_r;
  ensc_pkg::pp_t s5_sq_r, s5_p5_r, s5_p2_r;
  logic [31:0] s5_m5_r, s5_m6_r, s5_m3_r;
  logic [63:0] s6_sq_r, s6_w1p5_r, s6_w1p2_r;
  logic [31:0] s6_ha_r, s6_hb_r, s6_hc_r;
  ensc_pkg::pp_t s7_p6_r, s7_p3_r;
  logic [63:0] s7_w1p5_r, s7_w1p2_r;
  logic [31:0] s7_ha_r, s7_mbc_r;
  logic [63:0] s8_sqp6_r, s8_sqp3_r, s8_w1p5_r, s8_w1p2_r;
  logic [31:0] s8_ha_r, s8_he_r;
  logic [63:0] s9_w2_r, s9_sx_r;
  logic [31:0] s9_ha_r, s9_meh_r;
  ensc_pkg::pp_t s10_ps_r;
  logic [63:0] s10_num_r;
  logic [31:0] s10_ha_r, s10_hf_r;
  logic [63:0] s11_dv_r, s11_num_r;
  logic [31:0] s11_hva_r;
  ensc_pkg::div_t s12_d_r;

  logic [31:0] x1, dt, tc, tf5;
  logic [32:0] tadj;
  logic [63:0] pa;

  // first-stage temperature differences and later-stage sums
  always_comb begin
    x1   = {15'd0, adc_temp[19:3]} - {15'd0, cal.t1, 1'b0};
    dt   = {16'd0, adc_temp[19:4]} - {16'd0, cal.t1};
    tf5  = s3_tf_r + (s3_tf_r << 2) + ensc_pkg::C_T_RND;
    tc   = ensc_pkg::asr32(tf5, 8);
    tadj = {tc[31], tc} + {{18{cal.offset[14]}}, cal.offset};
    pa   = ensc_pkg::C_P_FULL - {44'd0, s9_ap_r};
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ensc_pkg::FRONT_DEPTH-2:0], in_v};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // temperature products
      s1_pv1_r <= ensc_pkg::mul32(x1, ensc_pkg::sx32_16(cal.t2));
      s1_dd_r  <= ensc_pkg::mul32(dt, dt);
      s1_ap_r  <= adc_press;
      s1_ah_r  <= adc_hum;

      s2_v1_r  <= ensc_pkg::asr32(s1_pv1_r, 11);
      s2_m2_r  <= ensc_pkg::mul32(ensc_pkg::asr32(s1_dd_r, 12), ensc_pkg::sx32_16(cal.t3));
      s2_ap_r  <= s1_ap_r;
      s2_ah_r  <= s1_ah_r;

      // fine temperature
      s3_tf_r  <= s2_v1_r + ensc_pkg::asr32(s2_m2_r, 14);
      s3_ap_r  <= s2_ap_r;
      s3_ah_r  <= s2_ah_r;

      // temperature outputs and pressure / humidity references
      s4_tcs_r <= ensc_pkg::sat16({tc[31], tc});
      s4_tas_r <= ensc_pkg::sat16(tadj);
      s4_w1_r  <= {{32{s3_tf_r[31]}}, s3_tf_r} - ensc_pkg::C_P_TREF;
      s4_hv_r  <= s3_tf_r - ensc_pkg::C_H_TREF;
      s4_ap_r  <= s3_ap_r;
      s4_ah_r  <= s3_ah_r;

      // first pressure partial products, humidity products
      s5_sq_r  <= ensc_pkg::pp(s4_w1_r, s4_w1_r);
      s5_p5_r  <= ensc_pkg::pp(s4_w1_r, ensc_pkg::sx64_16(cal.p5));
      s5_p2_r  <= ensc_pkg::pp(s4_w1_r, ensc_pkg::sx64_16(cal.p2));
      s5_m5_r  <= ensc_pkg::mul32(ensc_pkg::sx32_12(cal.h5), s4_hv_r);
      s5_m6_r  <= ensc_pkg::mul32(s4_hv_r, ensc_pkg::sx32_8(cal.h6));
      s5_m3_r  <= ensc_pkg::mul32(s4_hv_r, {24'd0, cal.h3});
      s5_tcs_r <= s4_tcs_r;
      s5_tas_r <= s4_tas_r;
      s5_ap_r  <= s4_ap_r;
      s5_ah_r  <= s4_ah_r;

      s6_sq_r   <= ensc_pkg::pp_sum(s5_sq_r);
      s6_w1p5_r <= ensc_pkg::pp_sum(s5_p5_r);
      s6_w1p2_r <= ensc_pkg::pp_sum(s5_p2_r);
      s6_ha_r   <= ensc_pkg::asr32({2'd0, s5_ah_r, 14'd0} - {cal.h4, 20'd0} - s5_m5_r
                                   + ensc_pkg::C_H_RND_A, 15);
      s6_hb_r   <= ensc_pkg::asr32(s5_m6_r, 10);
      s6_hc_r   <= ensc_pkg::asr32(s5_m3_r, 11) + ensc_pkg::C_H_C_OFS;
      s6_tcs_r  <= s5_tcs_r;
      s6_tas_r  <= s5_tas_r;
      s6_ap_r   <= s5_ap_r;

      s7_p6_r   <= ensc_pkg::pp(s6_sq_r, ensc_pkg::sx64_16(cal.p6));
      s7_p3_r   <= ensc_pkg::pp(s6_sq_r, ensc_pkg::sx64_16(cal.p3));
      s7_w1p5_r <= s6_w1p5_r;
      s7_w1p2_r <= s6_w1p2_r;
      s7_ha_r   <= s6_ha_r;
      s7_mbc_r  <= ensc_pkg::mul32(s6_hb_r, s6_hc_r);
      s7_tcs_r  <= s6_tcs_r;
      s7_tas_r  <= s6_tas_r;
      s7_ap_r   <= s6_ap_r;

      s8_sqp6_r <= ensc_pkg::pp_sum(s7_p6_r);
      s8_sqp3_r <= ensc_pkg::pp_sum(s7_p3_r);
      s8_w1p5_r <= s7_w1p5_r;
      s8_w1p2_r <= s7_w1p2_r;
      s8_ha_r   <= s7_ha_r;
      s8_he_r   <= ensc_pkg::asr32(s7_mbc_r, 10) + ensc_pkg::C_H_E_OFS;
      s8_tcs_r  <= s7_tcs_r;
      s8_tas_r  <= s7_tas_r;
      s8_ap_r   <= s7_ap_r;

      // pressure offset term and divisor base
      s9_w2_r   <= s8_sqp6_r + (s8_w1p5_r << 17) + (ensc_pkg::sx64_16(cal.p4) << 35);
      s9_sx_r   <= ensc_pkg::C_P_BIAS + ensc_pkg::asr64(s8_sqp3_r, 8) + (s8_w1p2_r << 12);
      s9_ha_r   <= s8_ha_r;
      s9_meh_r  <= ensc_pkg::mul32(s8_he_r, ensc_pkg::sx32_16(cal.h2));
      s9_tcs_r  <= s8_tcs_r;
      s9_tas_r  <= s8_tas_r;
      s9_ap_r   <= s8_ap_r;

      s10_ps_r  <= ensc_pkg::pp(s9_sx_r, {48'd0, cal.p1});
      s10_num_r <= ((pa << 31) - s9_w2_r) * ensc_pkg::C_P_SCALE;
      s10_ha_r  <= s9_ha_r;
      s10_hf_r  <= ensc_pkg::asr32(s9_meh_r + ensc_pkg::C_H_RND_F, 14);
      s10_tcs_r <= s9_tcs_r;
      s10_tas_r <= s9_tas_r;

      s11_dv_r  <= ensc_pkg::asr64(ensc_pkg::pp_sum(s10_ps_r), 33);
      s11_num_r <= s10_num_r;
      s11_hva_r <= ensc_pkg::mul32(s10_ha_r, s10_hf_r);
      s11_tcs_r <= s10_tcs_r;
      s11_tas_r <= s10_tas_r;

      // divider operands as magnitudes plus quotient sign
      s12_d_r.rem         <= '0;
      s12_d_r.nq          <= s11_num_r[63] ? (64'd0 - s11_num_r) : s11_num_r;
      s12_d_r.dvs         <= s11_dv_r[63] ? (64'd0 - s11_dv_r) : s11_dv_r;
      s12_d_r.side.neg    <= s11_num_r[63] ^ s11_dv_r[63];
      s12_d_r.side.pvalid <= (s11_dv_r != 64'd0);
      s12_d_r.side.hva    <= s11_hva_r;
      s12_d_r.side.hs     <= ensc_pkg::asr32(s11_hva_r, 15);
      s12_d_r.side.tcs    <= s11_tcs_r;
      s12_d_r.side.tas    <= s11_tas_r;
    end
  end

  assign out_v = v_r[ensc_pkg::FRONT_DEPTH-1];
  assign out_d = s12_d_r;

endmodule

`default_nettype wire

// ===== rtl/ensc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ensc_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder and produces one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ensc_div_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_v,
  input  wire ensc_pkg::div_t in_d,
  output logic                out_v,
  output ensc_pkg::div_t      out_d
);

  logic           v_r;
  ensc_pkg::div_t d_r;
  ensc_pkg::div_t d_nxt;
  logic [64:0]    sh;
  logic           ge;

  // trial subtract of the divisor
  always_comb begin
    sh        = {in_d.rem, in_d.nq[63]};
    ge        = (sh >= {1'b0, in_d.dvs});
    d_nxt     = in_d;
    d_nxt.rem = ge ? 64'(sh - {1'b0, in_d.dvs}) : sh[63:0];
    d_nxt.nq  = {in_d.nq[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

`default_nettype wire

// ===== rtl/ensc_back.sv =====
// ----------------------------------------------------------------------------
// ensc_back
// Pressure correction after the divider and humidity finish; forms one
// saturated result item.
// ----------------------------------------------------------------------------
`default_nettype none

module ensc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire ensc_pkg::cal_t cal,
  input  wire logic           in_v,
  input  wire ensc_pkg::div_t in_d,
  output logic                out_v,
  output ensc_pkg::item_t     out_item
);

  logic [ensc_pkg::BACK_DEPTH-1:0] v_r;

  logic [63:0] b1_p_r, b2_p_r, b3_p_r, b4_p_r, b5_p_r;
  logic [15:0] b1_tcs_r, b2_tcs_r, b3_tcs_r, b4_tcs_r, b5_tcs_r;
  logic [15:0] b1_tas_r, b2_tas_r, b3_tas_r, b4_tas_r, b5_tas_r;
  logic        b1_pv_r, b2_pv_r, b3_pv_r, b4_pv_r, b5_pv_r;
  logic [31:0] b1_hva_r, b2_hva_r, b1_ss_r, b2_xh_r;
  logic [16:0] b3_hum_r, b4_hum_r, b5_hum_r;
  logic [63:0] b2_q_r, b3_q_r;
  ensc_pkg::pp_t b2_a_r, b2_e2_r, b4_e1_r;
  logic [63:0] b3_a_r, b3_e2_r, b4_e2_r, b5_e2_r, b5_e1_r;

  logic [31:0] hv, hc;
  logic [63:0] pr;
  logic [31:0] pq;

  // humidity clamp and final pressure correction
  always_comb begin
    hv = b2_hva_r - ensc_pkg::asr32(b2_xh_r, 4);
    if (hv[31]) begin
      hc = 32'd0;
    end else if (hv > ensc_pkg::C_H_MAX) begin
      hc = ensc_pkg::C_H_MAX;
    end else begin
      hc = hv;
    end
    pr = ensc_pkg::asr64(b5_p_r + b5_e1_r + b5_e2_r, 8) + (ensc_pkg::sx64_16(cal.p7) << 4);
    if (!b5_pv_r || pr[63]) begin
      pq = 32'd0;
    end else if (pr[63:32] != 32'd0) begin
      pq = 32'hffff_ffff;
    end else begin
      pq = pr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ensc_pkg::BACK_DEPTH-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // signed quotient
      b1_p_r   <= in_d.side.neg ? (64'd0 - in_d.nq) : in_d.nq;
      b1_ss_r  <= ensc_pkg::mul32(in_d.side.hs, in_d.side.hs);
      b1_hva_r <= in_d.side.hva;
      b1_tcs_r <= in_d.side.tcs;
      b1_tas_r <= in_d.side.tas;
      b1_pv_r  <= in_d.side.pvalid;

      b2_q_r   <= ensc_pkg::asr64(b1_p_r, 13);
      b2_a_r   <= ensc_pkg::pp(ensc_pkg::sx64_16(cal.p9), ensc_pkg::asr64(b1_p_r, 13));
      b2_e2_r  <= ensc_pkg::pp(ensc_pkg::sx64_16(cal.p8), b1_p_r);
      b2_xh_r  <= ensc_pkg::mul32(ensc_pkg::asr32(b1_ss_r, 7), {24'd0, cal.h1});
      b2_hva_r <= b1_hva_r;
      b2_p_r   <= b1_p_r;
      b2_tcs_r <= b1_tcs_r;
      b2_tas_r <= b1_tas_r;
      b2_pv_r  <= b1_pv_r;

      b3_a_r   <= ensc_pkg::pp_sum(b2_a_r);
      b3_e2_r  <= ensc_pkg::asr64(ensc_pkg::pp_sum(b2_e2_r), 19);
      b3_hum_r <= hc[28:12];
      b3_q_r   <= b2_q_r;
      b3_p_r   <= b2_p_r;
      b3_tcs_r <= b2_tcs_r;
      b3_tas_r <= b2_tas_r;
      b3_pv_r  <= b2_pv_r;

      b4_e1_r  <= ensc_pkg::pp(b3_a_r, b3_q_r);
      b4_e2_r  <= b3_e2_r;
      b4_hum_r <= b3_hum_r;
      b4_p_r   <= b3_p_r;
      b4_tcs_r <= b3_tcs_r;
      b4_tas_r <= b3_tas_r;
      b4_pv_r  <= b3_pv_r;

      b5_e1_r  <= ensc_pkg::asr64(ensc_pkg::pp_sum(b4_e1_r), 25);
      b5_e2_r  <= b4_e2_r;
      b5_hum_r <= b4_hum_r;
      b5_p_r   <= b4_p_r;
      b5_tcs_r <= b4_tcs_r;
      b5_tas_r <= b4_tas_r;
      b5_pv_r  <= b4_pv_r;
    end
  end

  assign out_v                        = v_r[ensc_pkg::BACK_DEPTH-1];
  assign out_item.temp_centi          = b5_tcs_r;
  assign out_item.temp_adjusted_centi = b5_tas_r;
  assign out_item.pressure_q24_8      = pq;
  assign out_item.pressure_valid      = b5_pv_r;
  assign out_item.humidity_q22_10     = b5_hum_r;

endmodule

`default_nettype wire

// ===== rtl/env_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity samples.
// Path from request acceptance to out_valid: 12 front stages, 64 divider
//   cells at one quotient bit each, 5 back stages and the output register.
// Throughput: one request per cycle while in_stall is low; the single-bit divider cell chain sets it.
// A one-entry skid buffer lets the pipeline take one more result while the
//   output is stalled; in_stall follows the skid occupancy.
// Reset: synchronous active-low rst_n clears all valid bits and sets every
//   calibration register to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [19:0]        in_adc_temp,
  input  wire logic [19:0]        in_adc_press,
  input  wire logic [15:0]        in_adc_hum,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_temp_centi,
  output logic signed [15:0]      out_temp_adjusted_centi,
  output logic [31:0]             out_pressure_q24_8,
  output logic                    out_pressure_valid,
  output logic [16:0]             out_humidity_q22_10,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [47:0] cal_temp_r;
  logic [63:0] cal_press_a_r, cal_press_b_r;
  logic [15:0] cal_press_c_r;
  logic [31:0] cal_hum_a_r, cal_hum_b_r;
  logic [14:0] temp_offset_r;

  ensc_pkg::cal_t  cal;
  logic            adv;
  logic            front_v, back_v;
  ensc_pkg::div_t  front_d;
  ensc_pkg::item_t back_item;
  logic            cell_v [ensc_pkg::DIV_BITS+1];
  ensc_pkg::div_t  cell_d [ensc_pkg::DIV_BITS+1];

  logic            out_valid_r, skid_v_r;
  ensc_pkg::item_t out_r, skid_r;

  // configuration register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
      cal_hum_a_r   <= '0;
      cal_hum_b_r   <= '0;
      temp_offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ensc_pkg::CFG_CAL_TEMP:    cal_temp_r    <= cfg_data[47:0];
        ensc_pkg::CFG_CAL_PRESS_A: cal_press_a_r <= cfg_data;
        ensc_pkg::CFG_CAL_PRESS_B: cal_press_b_r <= cfg_data;
        ensc_pkg::CFG_CAL_PRESS_C: cal_press_c_r <= cfg_data[15:0];
        ensc_pkg::CFG_CAL_HUM_A:   cal_hum_a_r   <= cfg_data[31:0];
        ensc_pkg::CFG_CAL_HUM_B:   cal_hum_b_r   <= cfg_data[31:0];
        ensc_pkg::CFG_TEMP_OFFSET: temp_offset_r <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // coefficient unpacking
  always_comb begin
    cal.t1     = cal_temp_r[15:0];
    cal.t2     = cal_temp_r[31:16];
    cal.t3     = cal_temp_r[47:32];
    cal.p1     = cal_press_a_r[15:0];
    cal.p2     = cal_press_a_r[31:16];
    cal.p3     = cal_press_a_r[47:32];
    cal.p4     = cal_press_a_r[63:48];
    cal.p5     = cal_press_b_r[15:0];
    cal.p6     = cal_press_b_r[31:16];
    cal.p7     = cal_press_b_r[47:32];
    cal.p8     = cal_press_b_r[63:48];
    cal.p9     = cal_press_c_r;
    cal.h1     = cal_hum_a_r[7:0];
    cal.h2     = cal_hum_a_r[23:8];
    cal.h3     = cal_hum_a_r[31:24];
    cal.h4     = cal_hum_b_r[11:0];
    cal.h5     = cal_hum_b_r[23:12];
    cal.h6     = cal_hum_b_r[31:24];
    cal.offset = temp_offset_r;
  end

  // whole pipeline advances unless the skid entry is occupied
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  ensc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cal       (cal),
    .in_v      (in_valid),
    .adc_temp  (in_adc_temp),
    .adc_press (in_adc_press),
    .adc_hum   (in_adc_hum),
    .out_v     (front_v),
    .out_d     (front_d)
  );

  assign cell_v[0] = front_v;
  assign cell_d[0] = front_d;

  // divider chain, one quotient bit per cell
  for (genvar g = 0; g < ensc_pkg::DIV_BITS; g++) begin : g_div
    ensc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .in_v  (cell_v[g]),
      .in_d  (cell_d[g]),
      .out_v (cell_v[g+1]),
      .out_d (cell_d[g+1])
    );
  end

  ensc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cal      (cal),
    .in_v     (cell_v[ensc_pkg::DIV_BITS]),
    .in_d     (cell_d[ensc_pkg::DIV_BITS]),
    .out_v    (back_v),
    .out_item (back_item)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= back_v;
      end
    end else if (back_v && adv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_v_r ? skid_r : back_item;
    end else if (back_v && adv) begin
      skid_r <= back_item;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_temp_centi          = out_r.temp_centi;
  assign out_temp_adjusted_centi = out_r.temp_adjusted_centi;
  assign out_pressure_q24_8      = out_r.pressure_q24_8;
  assign out_pressure_valid      = out_r.pressure_valid;
  assign out_humidity_q22_10     = out_r.humidity_q22_10;

  // skid entry only holds while a result is shown
  assert property (@(posedge clk) disable iff (!rst_n) skid_v_r |-> out_valid_r)
    else $error("skid entry occupied without a shown result");

  // skid drains as soon as the output is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_stall |=> !skid_v_r && out_valid_r)
    else $error("skid entry not drained");

  // divisor of zero forces pressure to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pressure_valid |-> out_pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

  // humidity clamp
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

endmodule

`default_nettype wire
